### hdl/rri_pkg.sv
// rri_pkg: shared types and constants for the ray / rectangle intersect block
// no dependencies
package rri_pkg;

  localparam int unsigned NumW  = 48;   // |origin_n| << 16
  localparam int unsigned DenW  = 32;   // |dir_n|

  localparam logic [1:0] PLANE_XY = 2'd0;
  localparam logic [1:0] PLANE_XZ = 2'd1;
  localparam logic [1:0] PLANE_YZ = 2'd2;

  localparam logic [1:0] REG_PLANE = 2'd0;
  localparam logic [1:0] REG_SIZE1 = 2'd1;
  localparam logic [1:0] REG_SIZE2 = 2'd2;
  localparam logic [1:0] REG_EPS   = 2'd3;

  // ray data that rides alongside the divider
  typedef struct packed {
    logic signed [31:0] ox;
    logic signed [31:0] oy;
    logic signed [31:0] oz;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [31:0] dz;
    logic               qneg;   // quotient sign
    logic               nneg;   // normal points along minus axis
  } rri_side_t;

endpackage

### hdl/rri_div.sv
// rri_div: pipelined unsigned restoring divider, one quotient bit per stage
// depends on rri_pkg
module rri_div
  import rri_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_vld,
  input  logic [NumW-1:0]     in_num,
  input  logic [DenW-1:0]     in_den,
  input  rri_side_t           in_side,
  output logic                out_vld,
  output logic [NumW-1:0]     out_quo,
  output rri_side_t           out_side
);

  logic                vld_r  [NumW];
  logic [DenW-1:0]     rem_r  [NumW];
  logic [NumW-1:0]     nq_r   [NumW];  // numerator bits shift out, quotient bits shift in
  logic [DenW-1:0]     den_r  [NumW];
  rri_side_t           side_r [NumW];

  for (genvar g = 0; g < NumW; g++) begin : g_stage
    logic            p_vld;
    logic [DenW-1:0] p_rem;
    logic [NumW-1:0] p_nq;
    logic [DenW-1:0] p_den;
    rri_side_t       p_side;
    logic [DenW:0]   rem_sh;
    logic [DenW:0]   diff;
    logic            qbit;

    if (g == 0) begin : g_first
      assign p_vld  = in_vld;
      assign p_rem  = '0;
      assign p_nq   = in_num;
      assign p_den  = in_den;
      assign p_side = in_side;
    end else begin : g_next
      assign p_vld  = vld_r[g-1];
      assign p_rem  = rem_r[g-1];
      assign p_nq   = nq_r[g-1];
      assign p_den  = den_r[g-1];
      assign p_side = side_r[g-1];
    end

    always_comb begin
      rem_sh = {p_rem, p_nq[NumW-1]};
      diff   = rem_sh - {1'b0, p_den};
      qbit   = (rem_sh >= {1'b0, p_den});
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g] <= 1'b0;
      end else if (en) begin
        vld_r[g] <= p_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g]  <= qbit ? diff[DenW-1:0] : rem_sh[DenW-1:0];
        nq_r[g]   <= {p_nq[NumW-2:0], qbit};
        den_r[g]  <= p_den;
        side_r[g] <= p_side;
      end
    end
  end

  assign out_vld  = vld_r[NumW-1];
  assign out_quo  = nq_r[NumW-1];
  assign out_side = side_r[NumW-1];

endmodule

### hdl/ray_rectangle_intersect.sv
// ray_rectangle_intersect: top level, ray against an axis-aligned rectangle
// depends on rri_pkg and rri_div
//
// Takes one ray per cycle (origin and direction, signed Q16.16) and tests it
// against a rectangle with one corner at the origin lying in the XY, XZ or YZ
// plane. Each ray gives zero or one hit beat. From input beat to result there
// is one selection stage, a 48-stage divider that makes one quotient bit per
// stage for t = -origin_n / dir_n, then saturation, multiply, shift-and-add
// and range-test stages. One ray is accepted every cycle; the whole pipeline
// holds while a result beat is stalled, and the input stall follows that.
// Configuration must be written only while idle; the block does not check.
module ray_rectangle_intersect
  import rri_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               cfg_wr_en,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,

  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_distance_t,
  output logic signed [31:0] out_hit_x,
  output logic signed [31:0] out_hit_y,
  output logic signed [31:0] out_hit_z,
  output logic               out_normal_negative
);

  // configuration registers
  logic [1:0]  plane_r;
  logic [30:0] size1_r;
  logic [30:0] size2_r;
  logic [15:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plane_r <= PLANE_XY;
      size1_r <= 31'd65536;
      size2_r <= 31'd65536;
      eps_r   <= 16'd1;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_PLANE: plane_r <= cfg_data[1:0];
        REG_SIZE1: size1_r <= cfg_data;
        REG_SIZE2: size2_r <= cfg_data;
        REG_EPS:   eps_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless a finished beat is held
  logic en;
  logic out_valid_r;
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage 1: pick normal axis, magnitudes, parallel test
  logic signed [31:0] on_c, dn_c;
  logic [31:0]        on_mag_c, dn_mag_c;
  logic               plane_ok_c, keep_c;
  rri_side_t          side_c;

  always_comb begin
    plane_ok_c = 1'b1;
    unique case (plane_r)
      PLANE_XY: begin on_c = in_origin_z; dn_c = in_dir_z; end
      PLANE_XZ: begin on_c = in_origin_y; dn_c = in_dir_y; end
      PLANE_YZ: begin on_c = in_origin_x; dn_c = in_dir_x; end
      default:  begin on_c = in_origin_z; dn_c = in_dir_z; plane_ok_c = 1'b0; end
    endcase
    on_mag_c = on_c[31] ? 32'(-on_c) : 32'(on_c);
    dn_mag_c = dn_c[31] ? 32'(-dn_c) : 32'(dn_c);
    // parallel when zero or below epsilon
    keep_c   = plane_ok_c && (dn_c != 32'sd0) && (dn_mag_c >= {16'd0, eps_r});
    side_c.ox   = in_origin_x;
    side_c.oy   = in_origin_y;
    side_c.oz   = in_origin_z;
    side_c.dx   = in_dir_x;
    side_c.dy   = in_dir_y;
    side_c.dz   = in_dir_z;
    side_c.nneg = !(on_c > 32'sd0);
    // -origin_n is negative exactly when origin_n > 0
    side_c.qneg = (on_c > 32'sd0) ^ dn_c[31];
  end

  logic            s1_vld_r;
  logic [NumW-1:0] s1_num_r;
  logic [DenW-1:0] s1_den_r;
  rri_side_t       s1_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid && keep_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_num_r  <= {on_mag_c, 16'd0};
      s1_den_r  <= dn_mag_c;
      s1_side_r <= side_c;
    end
  end

  // divider stages
  logic            dv_vld;
  logic [NumW-1:0] dv_quo;
  rri_side_t       dv_side;

  rri_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s1_vld_r),
    .in_num   (s1_num_r),
    .in_den   (s1_den_r),
    .in_side  (s1_side_r),
    .out_vld  (dv_vld),
    .out_quo  (dv_quo),
    .out_side (dv_side)
  );

  // saturate the signed quotient into t
  logic signed [31:0] t_c;
  always_comb begin
    if (dv_side.qneg) begin
      t_c = (dv_quo > NumW'(64'h8000_0000)) ? 32'sh8000_0000 : 32'(-dv_quo[31:0]);
    end else begin
      t_c = (dv_quo > NumW'(64'h7fff_ffff)) ? 32'sh7fff_ffff : 32'(dv_quo[31:0]);
    end
  end

  logic               s2_vld_r;
  logic signed [31:0] s2_t_r;
  rri_side_t          s2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (en) begin
      s2_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_t_r    <= t_c;
      s2_side_r <= dv_side;
    end
  end

  // stage 3: t * dir per axis
  logic               s3_vld_r;
  logic signed [31:0] s3_t_r;
  logic signed [63:0] s3_px_r, s3_py_r, s3_pz_r;
  rri_side_t          s3_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= s2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_t_r    <= s2_t_r;
      s3_px_r   <= s2_t_r * s2_side_r.dx;
      s3_py_r   <= s2_t_r * s2_side_r.dy;
      s3_pz_r   <= s2_t_r * s2_side_r.dz;
      s3_side_r <= s2_side_r;
    end
  end

  // stage 4: divide by 65536 toward zero, add origin
  function automatic logic signed [48:0] add_scaled(input logic signed [63:0] p,
                                                    input logic signed [31:0] o);
    logic signed [63:0] b;
    logic signed [47:0] q;
    b = p + (p[63] ? 64'sd65535 : 64'sd0);
    q = b[63:16];
    return 49'(o) + 49'(q);
  endfunction

  logic               s4_vld_r;
  logic signed [31:0] s4_t_r;
  logic signed [48:0] s4_hx_r, s4_hy_r, s4_hz_r;
  logic               s4_nneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_t_r    <= s3_t_r;
      s4_hx_r   <= add_scaled(s3_px_r, s3_side_r.ox);
      s4_hy_r   <= add_scaled(s3_py_r, s3_side_r.oy);
      s4_hz_r   <= add_scaled(s3_pz_r, s3_side_r.oz);
      s4_nneg_r <= s3_side_r.nneg;
    end
  end

  // stage 5: in-plane range test, saturate, output register
  function automatic logic in_rng(input logic signed [48:0] v, input logic [30:0] sz);
    return !v[48] && (v <= 49'(sz));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [48:0] v);
    if (v > 49'sh0_7fff_ffff)       return 32'sh7fff_ffff;
    else if (v < -49'sh0_8000_0000) return 32'sh8000_0000;
    else                            return v[31:0];
  endfunction

  logic hit_c;
  always_comb begin
    unique case (plane_r)
      PLANE_XY: hit_c = in_rng(s4_hx_r, size1_r) && in_rng(s4_hy_r, size2_r);
      PLANE_XZ: hit_c = in_rng(s4_hx_r, size1_r) && in_rng(s4_hz_r, size2_r);
      PLANE_YZ: hit_c = in_rng(s4_hy_r, size1_r) && in_rng(s4_hz_r, size2_r);
      default:  hit_c = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= s4_vld_r && hit_c;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_distance_t      <= s4_t_r;
      out_hit_x           <= sat32(s4_hx_r);
      out_hit_y           <= sat32(s4_hy_r);
      out_hit_z           <= sat32(s4_hz_r);
      out_normal_negative <= s4_nneg_r;
    end
  end

  assign out_valid = out_valid_r;

  // a beat right after reset is never valid
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  // an XY hit lies inside the rectangle
  a_xy_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && plane_r == PLANE_XY |->
      !out_hit_x[31] && ({1'b0, out_hit_x} <= {2'b0, size1_r}))
    else $error("xy hit outside first extent");

  a_xy_y_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && plane_r == PLANE_XY |->
      !out_hit_y[31] && ({1'b0, out_hit_y} <= {2'b0, size2_r}))
    else $error("xy hit outside second extent");

  // the input side stalls only while a result beat is held
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with no held result");

endmodule

### tb/sv/ray_rectangle_intersect_tb.sv
// ray_rectangle_intersect_tb: self-checking testbench for the ray / rectangle intersect block
// depends on rri_pkg and ray_rectangle_intersect
module ray_rectangle_intersect_tb
  import rri_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // one expected hit beat
  typedef struct {
    logic signed [31:0] tval;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic signed [31:0] hz;
    logic               nneg;
  } hit_t;

  // predicts hits from rays and checks the result beats in order
  class hit_scoreboard;
    logic [1:0]  plane;
    logic [30:0] extent_a;
    logic [30:0] extent_b;
    logic [15:0] eps;
    hit_t        pending[$];
    int          errors;

    function void set_reg(logic [1:0] idx, logic [30:0] val);
      case (idx)
        REG_PLANE: plane = val[1:0];
        REG_SIZE1: extent_a = val;
        REG_SIZE2: extent_b = val;
        REG_EPS:   eps = val[15:0];
        default: ;
      endcase
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // note one accepted ray, queue its hit if any
    function void note_ray(logic signed [31:0] o[3], logic signed [31:0] d[3]);
      int nax, ax1, ax2;
      longint dn, mag, t;
      longint h[3];
      hit_t e;
      case (plane)
        PLANE_XY: begin nax = 2; ax1 = 0; ax2 = 1; end
        PLANE_XZ: begin nax = 1; ax1 = 0; ax2 = 2; end
        PLANE_YZ: begin nax = 0; ax1 = 1; ax2 = 2; end
        default: return;
      endcase
      dn = d[nax];
      mag = dn < 0 ? -dn : dn;
      if (dn == 0 || mag < longint'(eps)) return;
      t = clamp32((-longint'(o[nax]) * 65536) / dn);
      for (int i = 0; i < 3; i++) h[i] = longint'(o[i]) + (t * longint'(d[i])) / 65536;
      if (h[ax1] < 0 || h[ax1] > longint'(extent_a)) return;
      if (h[ax2] < 0 || h[ax2] > longint'(extent_b)) return;
      e.tval = t[31:0];
      e.hx = 32'(clamp32(h[0]));
      e.hy = 32'(clamp32(h[1]));
      e.hz = 32'(clamp32(h[2]));
      e.nneg = (o[nax] > 0) ? 1'b0 : 1'b1;
      pending = {pending, e};
    endfunction

    function void check_hit(hit_t got);
      hit_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected hit beat t=%0d", $realtime, got.tval);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.tval !== e.tval) begin
        $display("%0t: distance_t exp %0d got %0d", $realtime, e.tval, got.tval);
        errors++;
      end
      if (got.hx !== e.hx) begin
        $display("%0t: hit_x exp %0d got %0d", $realtime, e.hx, got.hx);
        errors++;
      end
      if (got.hy !== e.hy) begin
        $display("%0t: hit_y exp %0d got %0d", $realtime, e.hy, got.hy);
        errors++;
      end
      if (got.hz !== e.hz) begin
        $display("%0t: hit_z exp %0d got %0d", $realtime, e.hz, got.hz);
        errors++;
      end
      if (got.nneg !== e.nneg) begin
        $display("%0t: normal_negative exp %0b got %0b", $realtime, e.nneg, got.nneg);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic cfg_wr_en;
  logic [1:0] cfg_index;
  logic [30:0] cfg_data;
  logic in_valid, in_stall;
  logic signed [31:0] in_origin_x, in_origin_y, in_origin_z;
  logic signed [31:0] in_dir_x, in_dir_y, in_dir_z;
  logic out_valid, out_stall;
  logic signed [31:0] out_distance_t, out_hit_x, out_hit_y, out_hit_z;
  logic out_normal_negative;

  hit_scoreboard sb = new();
  bit no_idle;       // stretch with no idling on either side
  int hits_seen;

  ray_rectangle_intersect i_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #20ms;
    $display("FAIL");
    $finish;
  end

  // result side: random stall, check each accepted beat
  initial begin
    hit_t got;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.tval = out_distance_t;
        got.hx = out_hit_x;
        got.hy = out_hit_y;
        got.hz = out_hit_z;
        got.nneg = out_normal_negative;
        sb.check_hit(got);
        hits_seen++;
      end
      out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < 21);
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  // wait for every hit, then let the pipeline drain rays that give none
  task automatic drain();
    int guard;
    guard = 0;
    while (sb.pending.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (80) @(posedge clk);
  endtask

  // send one ray beat, with an optional idle gap before it
  task automatic send_ray(logic signed [31:0] o[3], logic signed [31:0] d[3]);
    if (!no_idle) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_origin_x <= o[0];
    in_origin_y <= o[1];
    in_origin_z <= o[2];
    in_dir_x <= d[0];
    in_dir_y <= d[1];
    in_dir_z <= d[2];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_ray(o, d);
  endtask

  function automatic logic signed [31:0] rand_word(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(32'h00030000);
      2: return -$signed($urandom_range(32'h00030000));
      3: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $signed($urandom_range(32'h000fffff)) - 32'sh00080000;
    endcase
  endfunction

  // build a ray aimed inside the rectangle most of the time
  task automatic random_ray();
    logic signed [31:0] o[3], d[3];
    int nax;
    case (sb.plane)
      PLANE_XY: nax = 2;
      PLANE_XZ: nax = 1;
      default:  nax = 0;
    endcase
    if ($urandom_range(99) < 75) begin
      for (int i = 0; i < 3; i++) begin
        o[i] = $urandom_range(32'h00020000);
        d[i] = $signed($urandom_range(32'h00020000)) - 32'sh00010000;
      end
      o[nax] = $signed($urandom_range(32'h00040000)) - 32'sh00020000;
      d[nax] = (o[nax] > 0) ? -$signed($urandom_range(32'h00020000, 1))
                            : $signed($urandom_range(32'h00020000, 1));
      if ($urandom_range(9) == 0) d[nax] = $urandom_range(3) - 1;
    end else begin
      for (int i = 0; i < 3; i++) begin
        o[i] = rand_word($urandom_range(4));
        d[i] = rand_word($urandom_range(4));
      end
    end
    send_ray(o, d);
  endtask

  task automatic directed_rays();
    logic signed [31:0] o[3], d[3];
    // straight down onto the middle of the unit square
    o = '{32'sh8000, 32'sh8000, 32'sh10000}; d = '{0, 0, -32'sh10000}; send_ray(o, d);
    // origin below, going up
    o = '{32'sh4000, 32'sh4000, -32'sh20000}; d = '{0, 0, 32'sh10000}; send_ray(o, d);
    // origin on the plane
    o = '{32'sh1000, 32'sh1000, 0}; d = '{32'sh100, 0, 32'sh10000}; send_ray(o, d);
    // parallel
    o = '{0, 0, 32'sh10000}; d = '{32'sh10000, 0, 0}; send_ray(o, d);
    // tiny direction, saturating t
    o = '{0, 0, 32'sh7fffffff}; d = '{0, 0, -1}; send_ray(o, d);
    o = '{0, 0, 32'sh80000000}; d = '{0, 0, 1}; send_ray(o, d);
    // field extremes
    o = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
    d = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff}; send_ray(o, d);
    o = '{32'sh7fffffff, 32'sh80000000, -1}; d = '{-1, -1, 32'sh80000000}; send_ray(o, d);
    // corners and edges
    o = '{32'sh10000, 32'sh10000, 32'sh10000}; d = '{0, 0, -32'sh10000}; send_ray(o, d);
    o = '{0, 0, -32'sh10000}; d = '{0, 0, 32'sh10000}; send_ray(o, d);
    o = '{32'sh10001, 0, 32'sh10000}; d = '{0, 0, -32'sh10000}; send_ray(o, d);
    o = '{-1, 0, 32'sh10000}; d = '{0, 0, -32'sh10000}; send_ray(o, d);
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0; cfg_index = REG_PLANE; cfg_data = '0;
    in_valid = 1'b0;
    in_origin_x = '0; in_origin_y = '0; in_origin_z = '0;
    in_dir_x = '0; in_dir_y = '0; in_dir_z = '0;
    no_idle = 1'b0;
    hits_seen = 0;
    sb.errors = 0;
    sb.set_reg(REG_PLANE, 31'(PLANE_XY));
    sb.set_reg(REG_SIZE1, 31'd65536);
    sb.set_reg(REG_SIZE2, 31'd65536);
    sb.set_reg(REG_EPS, 31'd1);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_rays();
    in_valid <= 1'b0;
    drain();
    // zero epsilon
    write_reg(REG_EPS, 31'd0);
    directed_rays();
    in_valid <= 1'b0;
    drain();

    // phases over planes, sizes and epsilons, the unused plane code among them
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(REG_PLANE, 31'((ph == 7) ? 3 : ph % 3));
      case (ph)
        0: write_reg(REG_SIZE1, 31'h7fffffff);
        1: write_reg(REG_SIZE1, 31'd0);
        default: write_reg(REG_SIZE1, 31'($urandom_range(32'h00030000)));
      endcase
      case (ph)
        2: write_reg(REG_SIZE2, 31'h7fffffff);
        3: write_reg(REG_SIZE2, 31'd0);
        default: write_reg(REG_SIZE2, 31'($urandom_range(32'h00030000)));
      endcase
      case (ph)
        4: write_reg(REG_EPS, 31'd65535);
        5: write_reg(REG_EPS, 31'd0);
        default: write_reg(REG_EPS, 31'($urandom_range(32'h00008000)));
      endcase
      no_idle = (ph == 6);
      for (int k = 0; k < 113; k++) begin
        random_ray();
        // sender holds off until every hit is back
        if (ph == 8 && k == 50) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
      end
      in_valid <= 1'b0;
      no_idle = 1'b0;
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### sim.f
hdl/rri_pkg.sv
hdl/rri_div.sv
hdl/ray_rectangle_intersect.sv
tb/sv/ray_rectangle_intersect_tb.sv
